[rtl/tx_frame_queue_top_macros.svh]
// Assertion macros for the transmit frame queue.
// Expect clk_i and rst_ni in the scope of each use.
`ifndef TX_FRAME_QUEUE_TOP_MACROS_SVH
`define TX_FRAME_QUEUE_TOP_MACROS_SVH

// Implication checked at each rising edge out of reset.
`define TFQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold out of reset.
`define TFQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[rtl/tfq_pkg.sv]
// Shared types and constants of the transmit frame queue.
// No dependencies.
package tfq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned FRAME_BYTES_DEF = 64;
  localparam int unsigned CMD_FIFO_DEPTH  = 2;

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_POLL    = 2'd1,
    KIND_TX_DONE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    APP_NONE   = 2'd0,
    APP_ACCEPT = 2'd1,
    APP_REJECT = 2'd2,
    APP_DROP   = 2'd3
  } append_status_e;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_POLL,
    OP_TX_DONE,
    OP_NOP
  } op_e;

  typedef enum logic {
    BK_EXEC,
    BK_READ
  } back_state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] append_status;
    logic       busy_res;
    logic       queue_empty;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic sending;
    logic ring_empty;
  } back_status_t;

endpackage

[rtl/tfq_front.sv]
// Input stage of the transmit frame queue: accept and classify items.
// Depends on tfq_pkg.
module tfq_front import tfq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_i,
  output logic     cmd_valid_o,
  input  logic     cmd_stall_i,
  output cmd_t     cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  op_e  op;
  logic accept;

  always_comb begin
    case (kind_e'(in_i.kind))
      KIND_APPEND:  op = OP_APPEND;
      KIND_POLL:    op = OP_POLL;
      KIND_TX_DONE: op = OP_TX_DONE;
      default:      op = OP_NOP;
    endcase
  end

  assign in_stall_o = valid_q && cmd_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q && cmd_stall_i;
    cmd_d   = cmd_q;
    if (accept) begin
      valid_d    = 1'b1;
      cmd_d.op   = op;
      cmd_d.data = in_i.data_byte;
      cmd_d.last = in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

[rtl/tfq_queue.sv]
// Short command queue between the front and back of the frame queue.
// Depends on tfq_pkg.
module tfq_queue import tfq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_stall_o,
  input  cmd_t wr_cmd_i,
  output logic rd_valid_o,
  input  logic rd_stall_i,
  output cmd_t rd_cmd_o
);

  localparam int unsigned PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t          entry_q [CMD_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    if (p == PW'(CMD_FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign wr_stall_o = (count_q == CW'(CMD_FIFO_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_cmd_o   = entry_q[rd_ptr_q];
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_valid_o && !rd_stall_i;

  always_comb begin
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

[rtl/tfq_back.sv]
// Execution stage of the frame queue: slot ring, frame store and output register.
// Depends on tfq_pkg.
module tfq_back import tfq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_valid_i,
  output logic         cmd_stall_o,
  input  cmd_t         cmd_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output out_item_t    out_o,
  output back_status_t status_o
);

  localparam int unsigned SW          = $clog2(QUEUE_DEPTH);
  localparam int unsigned LW          = $clog2(FRAME_BYTES + 1);
  localparam int unsigned STORE_DEPTH = QUEUE_DEPTH * FRAME_BYTES;
  localparam int unsigned AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [LW-1:0] FB_LEN    = LW'(FRAME_BYTES);
  localparam logic [AW-1:0] FB_ADDR   = AW'(FRAME_BYTES);

  logic [7:0]    store_mem [STORE_DEPTH];
  logic [LW-1:0] len_mem   [QUEUE_DEPTH];

  back_state_e   state_q, state_d;
  logic [SW-1:0] head_q, head_d, tail_q, tail_d;
  logic [LW-1:0] rd_off_q, rd_off_d, wr_off_q, wr_off_d;
  logic          rejecting_q, rejecting_d, sending_q, sending_d;
  logic          load_len_q, load_len_d;
  logic [LW-1:0] head_len_q, head_len_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;
  logic [7:0]    byte_rd_q;
  logic [LW-1:0] len_rd_q;

  logic          out_free, fire, out_load;
  logic          st_we, len_we, rd_en, rej;
  logic [SW-1:0] rd_slot, head_nxt;
  logic [LW-1:0] rd_off, wr_off_n, len_wdata;
  logic [AW-1:0] wr_addr, rd_addr;

  function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
    if (s == SW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign fire        = (state_q == BK_EXEC) && cmd_valid_i && out_free;
  assign cmd_stall_o = !fire;
  assign head_nxt    = slot_next(head_q);
  assign rej         = rejecting_q || ((wr_off_q == '0) && (slot_next(tail_q) == head_q));
  assign wr_addr     = AW'(tail_q) * FB_ADDR + AW'(wr_off_q);
  assign rd_addr     = AW'(rd_slot) * FB_ADDR + AW'(rd_off);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rd_off_d    = rd_off_q;
    wr_off_d    = wr_off_q;
    rejecting_d = rejecting_q;
    sending_d   = sending_q;
    load_len_d  = load_len_q;
    head_len_d  = head_len_q;
    st_we       = 1'b0;
    len_we      = 1'b0;
    len_wdata   = wr_off_q;
    wr_off_n    = wr_off_q;
    rd_en       = 1'b0;
    rd_slot     = head_q;
    rd_off      = rd_off_q;
    out_load    = 1'b0;
    out_d       = out_q;

    out_d.tx_valid      = 1'b0;
    out_d.tx_byte       = '0;
    out_d.append_status = APP_NONE;
    out_d.busy_res      = sending_q;
    out_d.queue_empty   = (head_q == tail_q);

    case (state_q)
      BK_EXEC: begin
        if (fire) begin
          case (cmd_i.op)
            OP_APPEND: begin
              out_load = 1'b1;
              if (rej) begin
                out_d.append_status = APP_REJECT;
                rejecting_d         = !cmd_i.last;
                if (cmd_i.last) begin
                  wr_off_d = '0;
                end
              end else begin
                if (wr_off_q < FB_LEN) begin
                  st_we               = 1'b1;
                  wr_off_n            = wr_off_q + 1'b1;
                  out_d.append_status = APP_ACCEPT;
                end else begin
                  out_d.append_status = APP_DROP;
                end
                wr_off_d = wr_off_n;
                if (cmd_i.last) begin
                  len_we            = 1'b1;
                  len_wdata         = wr_off_n;
                  tail_d            = slot_next(tail_q);
                  wr_off_d          = '0;
                  out_d.queue_empty = (head_q == slot_next(tail_q));
                end
              end
            end
            OP_POLL: begin
              if ((head_q != tail_q) && !sending_q) begin
                rd_en      = 1'b1;
                rd_off_d   = rd_off_q + 1'b1;
                sending_d  = 1'b1;
                load_len_d = 1'b1;
                state_d    = BK_READ;
              end else begin
                out_load = 1'b1;
              end
            end
            OP_TX_DONE: begin
              if (!sending_q) begin
                out_load = 1'b1;
              end else if (rd_off_q < head_len_q) begin
                rd_en      = 1'b1;
                rd_off_d   = rd_off_q + 1'b1;
                load_len_d = 1'b0;
                state_d    = BK_READ;
              end else begin
                head_d = head_nxt;
                if (head_nxt != tail_q) begin
                  rd_en      = 1'b1;
                  rd_slot    = head_nxt;
                  rd_off     = '0;
                  rd_off_d   = LW'(1);
                  load_len_d = 1'b1;
                  state_d    = BK_READ;
                end else begin
                  out_load          = 1'b1;
                  sending_d         = 1'b0;
                  rd_off_d          = '0;
                  out_d.busy_res    = 1'b0;
                  out_d.queue_empty = 1'b1;
                end
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        out_load       = 1'b1;
        out_d.tx_valid = 1'b1;
        out_d.tx_byte  = byte_rd_q;
        if (load_len_q) begin
          head_len_d = len_rd_q;
        end
        state_d = BK_EXEC;
      end
      default: begin
        state_d = BK_EXEC;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_EXEC;
      head_q      <= '0;
      tail_q      <= '0;
      rd_off_q    <= '0;
      wr_off_q    <= '0;
      rejecting_q <= 1'b0;
      sending_q   <= 1'b0;
      load_len_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rd_off_q    <= rd_off_d;
      wr_off_q    <= wr_off_d;
      rejecting_q <= rejecting_d;
      sending_q   <= sending_d;
      load_len_q  <= load_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_len_q <= head_len_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[wr_addr] <= cmd_i.data;
    end
    if (rd_en) begin
      byte_rd_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[tail_q] <= len_wdata;
    end
    if (rd_en) begin
      len_rd_q <= len_mem[rd_slot];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_o               = out_q;
  assign status_o.sending    = sending_q;
  assign status_o.ring_empty = (head_q == tail_q);

endmodule

[rtl/tx_frame_queue_top.sv]
// Path: an item is registered in the front stage, in the command queue and in the back
// stage's output register; a byte hand-out also passes the registered frame store read.
// Throughput: appends one item per cycle when the output does not stall; the back stage
// takes no new item while it waits on the registered read of a byte from the frame store.
// Reset: ring empty, transmitter idle, queues flushed; no clearing pass.
module tx_frame_queue_top import tfq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  `include "tx_frame_queue_top_macros.svh"

  logic         f_valid, f_stall;
  cmd_t         f_cmd;
  logic         q_valid, q_stall;
  cmd_t         q_cmd;
  back_status_t status;

  tfq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .cmd_valid_o (f_valid),
    .cmd_stall_i (f_stall),
    .cmd_o       (f_cmd)
  );

  tfq_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_stall_o (f_stall),
    .wr_cmd_i   (f_cmd),
    .rd_valid_o (q_valid),
    .rd_stall_i (q_stall),
    .rd_cmd_o   (q_cmd)
  );

  tfq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_stall_o (q_stall),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .status_o    (status)
  );

  `TFQ_ASSERT_IMPLY(a_tx_implies_busy, out_valid_o && out_o.tx_valid, out_o.busy_res, "tx byte while idle")
  `TFQ_ASSERT_NEVER(a_busy_empty, out_valid_o && out_o.busy_res && out_o.queue_empty, "busy on empty ring")
  `TFQ_ASSERT_IMPLY(a_append_no_tx, out_valid_o && (out_o.append_status != APP_NONE), !out_o.tx_valid, "append with tx byte")
  `TFQ_ASSERT_IMPLY(a_sending_has_frame, status.sending, !status.ring_empty, "sending from empty ring")

endmodule
